[design/sip_pkg.sv]
// Shared types and widths for the segment intersection point pipeline.
// Depends on nothing; every other file refers to it by scoped names.
package sip_pkg;

  // Coordinate width; every internal width below follows from it.
  localparam int COORD_BITS = 16;
  // Difference of two coordinates.
  localparam int DIFF_W     = COORD_BITS + 1;
  // Product of two differences.
  localparam int PROD_W     = 2 * DIFF_W;
  // Cross product (difference of two products).
  localparam int CROSS_W    = PROD_W + 1;
  // Divisor |p1| + |p2|, dividend |p1| and running remainder.
  localparam int DEN_W      = CROSS_W + 1;
  // Quotient is below |d|, so it fits in a difference's width.
  localparam int QUO_W      = DIFF_W;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t seg_a_start_x;
    coord_t seg_a_start_y;
    coord_t seg_a_end_x;
    coord_t seg_a_end_y;
    coord_t seg_b_start_x;
    coord_t seg_b_start_y;
    coord_t seg_b_end_x;
    coord_t seg_b_end_y;
  } in_beat_t;

  typedef struct packed {
    logic   crosses;
    coord_t cross_x;
    coord_t cross_y;
  } out_beat_t;

  // One coordinate's share of the divider: the scale |d| is consumed MSB first.
  typedef struct packed {
    logic              neg;
    logic [DIFF_W-1:0] mag;
    coord_t            start;
    logic [DEN_W-1:0]  rem;
    logic [QUO_W-1:0]  quo;
  } div_axis_t;

  typedef struct packed {
    logic             crosses;
    logic [DEN_W-1:0] num;
    logic [DEN_W-1:0] den;
    div_axis_t        x;
    div_axis_t        y;
  } div_beat_t;

endpackage

[design/segment_intersection_point.sv]
// Pipeline: 4 front stages, COORD_BITS+1 divider steps and 1 output register.
// Throughput: one segment pair per cycle while not stalled; each divider step handles one bit of |d|.
// A consumer stall fills the one-beat skid buffer, then freezes the whole pipe.
// Reset clears all valid bits; no result is presented until a beat has gone through.
// Uses sip_pkg, sip_cross, sip_div_step and sip_skid.
module segment_intersection_point (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sip_pkg::in_beat_t   in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sip_pkg::out_beat_t  out_beat_o
);

  localparam int CoordW = sip_pkg::COORD_BITS;
  localparam int QuoW   = sip_pkg::QUO_W;

  logic               pipe_en;
  logic               div_valid [0:QuoW];
  sip_pkg::div_beat_t div_beat  [0:QuoW];
  sip_pkg::div_axis_t last_x, last_y;
  sip_pkg::out_beat_t result;

  assign in_stall_o = !pipe_en;

  sip_cross u_cross (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (pipe_en),
    .valid_i    (in_valid_i),
    .in_beat_i  (in_beat_i),
    .valid_o    (div_valid[0]),
    .div_beat_o (div_beat[0])
  );

  // One divider step per quotient bit.
  for (genvar i = 0; i < QuoW; i++) begin : g_div
    sip_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (div_valid[i]),
      .data_i  (div_beat[i]),
      .valid_o (div_valid[i+1]),
      .data_o  (div_beat[i+1])
    );
  end

  // Move from A's start along its direction; drop the point when there is no crossing.
  always_comb begin
    last_x         = div_beat[QuoW].x;
    last_y         = div_beat[QuoW].y;
    result.crosses = div_beat[QuoW].crosses;
    result.cross_x = '0;
    result.cross_y = '0;
    if (div_beat[QuoW].crosses) begin
      result.cross_x = last_x.neg ? last_x.start - last_x.quo[CoordW-1:0]
                                  : last_x.start + last_x.quo[CoordW-1:0];
      result.cross_y = last_y.neg ? last_y.start - last_y.quo[CoordW-1:0]
                                  : last_y.start + last_y.quo[CoordW-1:0];
    end
  end

  sip_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_valid[QuoW]),
    .data_i  (result),
    .ready_o (pipe_en),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_beat_o)
  );

endmodule

[design/sip_cross.sv]
// Front end: differences, products, cross products and the crossing test.
// Four register stages; uses sip_pkg types, feeds the divider chain.
module sip_cross (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  sip_pkg::in_beat_t    in_beat_i,
  output logic                 valid_o,
  output sip_pkg::div_beat_t   div_beat_o
);

  localparam int CoordW = sip_pkg::COORD_BITS;
  localparam int DiffW  = sip_pkg::DIFF_W;
  localparam int ProdW  = sip_pkg::PROD_W;
  localparam int CrossW = sip_pkg::CROSS_W;
  localparam int DenW   = sip_pkg::DEN_W;

  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;

  typedef struct packed {
    diff_t            dax, day;
    diff_t            obsx, obsy, obex, obey;
    diff_t            dbx, dby;
    diff_t            oasx, oasy, oaex, oaey;
    sip_pkg::coord_t  ax, ay;
  } s1_t;

  typedef struct packed {
    prod_t            m0, m1, m2, m3, m4, m5, m6, m7;
    diff_t            dax, day;
    sip_pkg::coord_t  ax, ay;
  } s2_t;

  typedef struct packed {
    cross_t           p1a, p2a, p1b, p2b;
    diff_t            dax, day;
    sip_pkg::coord_t  ax, ay;
  } s3_t;

  function automatic diff_t sub_c(sip_pkg::coord_t a, sip_pkg::coord_t b);
    return {a[CoordW-1], a} - {b[CoordW-1], b};
  endfunction

  function automatic prod_t mul_d(diff_t a, diff_t b);
    return prod_t'(a) * prod_t'(b);
  endfunction

  function automatic logic [CrossW-1:0] abs_c(cross_t p);
    return p[CrossW-1] ? CrossW'(-p) : CrossW'(p);
  endfunction

  function automatic logic [DiffW-1:0] abs_d(diff_t d);
    return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

  // Strictly opposite sides: both nonzero and signs differ.
  function automatic logic opposite(cross_t p, cross_t q);
    return (p != '0) && (q != '0) && (p[CrossW-1] != q[CrossW-1]);
  endfunction

  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  sip_pkg::div_beat_t s4_d, s4_q;
  logic [CrossW-1:0]  mag_p1b, mag_p2b;

  // Stage 1: direction vectors and endpoint offsets.
  always_comb begin
    s1_d.dax  = sub_c(in_beat_i.seg_a_end_x,   in_beat_i.seg_a_start_x);
    s1_d.day  = sub_c(in_beat_i.seg_a_end_y,   in_beat_i.seg_a_start_y);
    s1_d.obsx = sub_c(in_beat_i.seg_b_start_x, in_beat_i.seg_a_start_x);
    s1_d.obsy = sub_c(in_beat_i.seg_b_start_y, in_beat_i.seg_a_start_y);
    s1_d.obex = sub_c(in_beat_i.seg_b_end_x,   in_beat_i.seg_a_start_x);
    s1_d.obey = sub_c(in_beat_i.seg_b_end_y,   in_beat_i.seg_a_start_y);
    s1_d.dbx  = sub_c(in_beat_i.seg_b_end_x,   in_beat_i.seg_b_start_x);
    s1_d.dby  = sub_c(in_beat_i.seg_b_end_y,   in_beat_i.seg_b_start_y);
    s1_d.oasx = sub_c(in_beat_i.seg_a_start_x, in_beat_i.seg_b_start_x);
    s1_d.oasy = sub_c(in_beat_i.seg_a_start_y, in_beat_i.seg_b_start_y);
    s1_d.oaex = sub_c(in_beat_i.seg_a_end_x,   in_beat_i.seg_b_start_x);
    s1_d.oaey = sub_c(in_beat_i.seg_a_end_y,   in_beat_i.seg_b_start_y);
    s1_d.ax   = in_beat_i.seg_a_start_x;
    s1_d.ay   = in_beat_i.seg_a_start_y;
  end

  // Stage 2: the eight products of the four cross products.
  always_comb begin
    s2_d.m0  = mul_d(s1_q.dax, s1_q.obsy);
    s2_d.m1  = mul_d(s1_q.day, s1_q.obsx);
    s2_d.m2  = mul_d(s1_q.dax, s1_q.obey);
    s2_d.m3  = mul_d(s1_q.day, s1_q.obex);
    s2_d.m4  = mul_d(s1_q.dbx, s1_q.oasy);
    s2_d.m5  = mul_d(s1_q.dby, s1_q.oasx);
    s2_d.m6  = mul_d(s1_q.dbx, s1_q.oaey);
    s2_d.m7  = mul_d(s1_q.dby, s1_q.oaex);
    s2_d.dax = s1_q.dax;
    s2_d.day = s1_q.day;
    s2_d.ax  = s1_q.ax;
    s2_d.ay  = s1_q.ay;
  end

  // Stage 3: cross products.
  always_comb begin
    s3_d.p1a = cross_t'(s2_q.m0) - cross_t'(s2_q.m1);
    s3_d.p2a = cross_t'(s2_q.m2) - cross_t'(s2_q.m3);
    s3_d.p1b = cross_t'(s2_q.m4) - cross_t'(s2_q.m5);
    s3_d.p2b = cross_t'(s2_q.m6) - cross_t'(s2_q.m7);
    s3_d.dax = s2_q.dax;
    s3_d.day = s2_q.day;
    s3_d.ax  = s2_q.ax;
    s3_d.ay  = s2_q.ay;
  end

  // Stage 4: crossing test, dividend, divisor and divider seed.
  always_comb begin
    mag_p1b      = abs_c(s3_q.p1b);
    mag_p2b      = abs_c(s3_q.p2b);
    s4_d.crosses = opposite(s3_q.p1a, s3_q.p2a) && opposite(s3_q.p1b, s3_q.p2b);
    s4_d.num     = DenW'(mag_p1b);
    s4_d.den     = DenW'(mag_p1b) + DenW'(mag_p2b);
    s4_d.x.neg   = s3_q.dax[DiffW-1];
    s4_d.x.mag   = abs_d(s3_q.dax);
    s4_d.x.start = s3_q.ax;
    s4_d.x.rem   = '0;
    s4_d.x.quo   = '0;
    s4_d.y.neg   = s3_q.day[DiffW-1];
    s4_d.y.mag   = abs_d(s3_q.day);
    s4_d.y.start = s3_q.ay;
    s4_d.y.rem   = '0;
    s4_d.y.quo   = '0;
  end

  // Advance valid bits when the pipe moves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  // Advance payload; hold everything while stalled.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign valid_o    = s4_valid_q;
  assign div_beat_o = s4_q;

endmodule

[design/sip_div_step.sv]
// One registered step of the scaled divider: floor(|d| * num / den).
// Consumes one bit of |d| per step for both coordinates; uses sip_pkg types.
module sip_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  sip_pkg::div_beat_t  data_i,
  output logic                valid_o,
  output sip_pkg::div_beat_t  data_o
);

  localparam int DiffW = sip_pkg::DIFF_W;
  localparam int DenW  = sip_pkg::DEN_W;
  localparam int QuoW  = sip_pkg::QUO_W;
  localparam int TW    = DenW + 2;

  // rem' = 2*rem + bit*num, then subtract den up to twice (num < den keeps rem' < 3*den).
  function automatic sip_pkg::div_axis_t step_axis(sip_pkg::div_axis_t a,
                                                   logic [DenW-1:0] num,
                                                   logic [DenW-1:0] den);
    sip_pkg::div_axis_t res;
    logic [TW-1:0]      t;
    logic [TW-1:0]      den1;
    logic [TW-1:0]      den2;
    logic [TW-1:0]      r;
    logic [1:0]         dig;
    t    = TW'({a.rem, 1'b0}) + (a.mag[DiffW-1] ? TW'(num) : TW'(0));
    den1 = TW'(den);
    den2 = TW'({den, 1'b0});
    priority if (t >= den2) begin
      r   = t - den2;
      dig = 2'd2;
    end else if (t >= den1) begin
      r   = t - den1;
      dig = 2'd1;
    end else begin
      r   = t;
      dig = 2'd0;
    end
    res       = a;
    res.rem   = r[DenW-1:0];
    res.quo   = {a.quo[QuoW-2:0], 1'b0} + QuoW'(dig);
    res.mag   = {a.mag[DiffW-2:0], 1'b0};
    return res;
  endfunction

  logic               valid_q;
  sip_pkg::div_beat_t data_d, data_q;

  // Step both coordinates; shared fields pass through.
  always_comb begin
    data_d   = data_i;
    data_d.x = step_axis(data_i.x, data_i.num, data_i.den);
    data_d.y = step_axis(data_i.y, data_i.num, data_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[design/sip_skid.sv]
// Output register with a one-beat skid buffer behind it.
// Frees the pipeline from the consumer's stall; uses sip_pkg::out_beat_t.
module sip_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  sip_pkg::out_beat_t  data_i,
  output logic                ready_o,
  output logic                valid_o,
  input  logic                stall_i,
  output sip_pkg::out_beat_t  data_o
);

  logic               out_valid_d, out_valid_q;
  logic               skid_valid_d, skid_valid_q;
  sip_pkg::out_beat_t out_d, out_q;
  sip_pkg::out_beat_t skid_d, skid_q;
  logic               take;

  assign take = out_valid_q && !stall_i;

  // Refill the output from the skid first; otherwise route the incoming beat.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (valid_i) begin
      if (!out_valid_q || take) begin
        out_d       = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule
